FILE: rtl/chacha_pkg.sv
// Shared types, constants and register codes for the ChaCha20 byte cipher.
`default_nettype none
package chacha_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 16;
  localparam int NUM_LANES  = 4;
  localparam int POS_W      = 6;
  localparam int KEY_PART_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Four lanes run one add/xor/rotate per cycle: 4 sub-steps per quarter round,
  // 20 rounds per block.
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(79);

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNTER = 3'd6;

  // Quarter-round sub-steps and their rotate amounts.
  localparam logic [1:0] SUB_ROT16 = 2'd0;
  localparam logic [1:0] SUB_ROT12 = 2'd1;
  localparam logic [1:0] SUB_ROT8  = 2'd2;
  localparam logic [1:0] SUB_ROT7  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic       load;    // copy initial state into the working words
    logic       step;    // run one sub-step on all four lanes
    logic       diag;    // diagonal round when set, column round otherwise
    logic [1:0] sub;
    logic       finish;  // add initial state back, store keystream
    logic       accept;  // input request taken this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/chacha_qr.sv
// One quarter-round sub-step: x += y, z = rotl(z ^ x, r).
`default_nettype none
module chacha_qr (
  input  wire chacha_pkg::word_t x,
  input  wire chacha_pkg::word_t y,
  input  wire chacha_pkg::word_t z,
  input  wire logic [1:0]        sub,
  output chacha_pkg::word_t      x_new,
  output chacha_pkg::word_t      z_new
);
  import chacha_pkg::*;

  word_t mixed;

  assign x_new = x + y;
  assign mixed = z ^ x_new;

  always_comb begin
    unique case (sub)
      SUB_ROT16: z_new = {mixed[15:0], mixed[31:16]};
      SUB_ROT12: z_new = {mixed[19:0], mixed[31:20]};
      SUB_ROT8:  z_new = {mixed[23:0], mixed[31:24]};
      SUB_ROT7:  z_new = {mixed[24:0], mixed[31:25]};
      default:   z_new = mixed;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/chacha_ctrl.sv
// Sequencer: block generation steps and the input handshake.
`default_nettype none
module chacha_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire chacha_pkg::dp_status_t status,
  output chacha_pkg::dp_cmd_t         cmd
);
  import chacha_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FINAL, S_READY} state_t;

  state_t            state;
  logic [STEP_W-1:0] step_count;

  // A byte at block position zero waits for a fresh block.
  assign in_ready = status.out_free &&
                    ((state == S_READY) || (state == S_IDLE && !status.pos_zero));

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid && status.pos_zero;
    cmd.step   = (state == S_ROUND);
    cmd.diag   = step_count[2];
    cmd.sub    = step_count[1:0];
    cmd.finish = (state == S_FINAL);
    cmd.accept = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          step_count <= '0;
          if (in_valid && status.pos_zero) state <= S_ROUND;
        end
        S_ROUND: begin
          step_count <= step_count + 1'b1;
          if (step_count == STEP_LAST) state <= S_FINAL;
        end
        S_FINAL: state <= S_READY;
        S_READY: if (cmd.accept) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND || state == S_FINAL) |-> !in_ready)
    else $error("input taken during block generation");

  a_block_before_first_byte: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.pos_zero) |-> (state == S_READY))
    else $error("byte at position zero taken without a fresh block");

  a_full_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |-> ($past(state) == S_ROUND && $past(step_count) == STEP_LAST))
    else $error("block finished before all rounds ran");

endmodule
`default_nettype wire

FILE: rtl/chacha_dp.sv
// Datapath: config registers, working state, four quarter-round lanes, output register.
`default_nettype none
module chacha_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [chacha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [chacha_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire chacha_pkg::in_item_t               in_data,
  output chacha_pkg::out_item_t                   out_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  input  wire chacha_pkg::dp_cmd_t                cmd,
  output chacha_pkg::dp_status_t                  status
);
  import chacha_pkg::*;

  logic [KEY_PART_W-1:0] key_part [4];
  logic [63:0]           nonce_low;
  word_t                 nonce_high;
  word_t                 init_counter;
  word_t                 block_count;
  logic [POS_W-1:0]      byte_pos;

  word_t init_words [NUM_WORDS];
  word_t round_words [NUM_WORDS];
  word_t round_next [NUM_WORDS];
  word_t keystream [NUM_WORDS];

  word_t lane_x_new [NUM_LANES];
  word_t lane_z_new [NUM_LANES];

  word_t      ks_word;
  logic [7:0] ks_byte;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      init_words[n]         = SIGMA[n];
      init_words[4 + 2 * n] = key_part[n][31:0];
      init_words[5 + 2 * n] = key_part[n][63:32];
    end
    init_words[12] = block_count;
    init_words[13] = nonce_low[31:0];
    init_words[14] = nonce_low[63:32];
    init_words[15] = nonce_high;
  end

  // Each lane picks its column or diagonal; odd sub-steps work on (c, d, b).
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    localparam int A  = i;
    localparam int B0 = 4 + i;
    localparam int B1 = 4 + ((i + 1) % 4);
    localparam int C0 = 8 + i;
    localparam int C1 = 8 + ((i + 2) % 4);
    localparam int D0 = 12 + i;
    localparam int D1 = 12 + ((i + 3) % 4);

    word_t a, b, c, d, x, y, z;

    assign a = round_words[A];
    assign b = cmd.diag ? round_words[B1] : round_words[B0];
    assign c = cmd.diag ? round_words[C1] : round_words[C0];
    assign d = cmd.diag ? round_words[D1] : round_words[D0];
    assign x = cmd.sub[0] ? c : a;
    assign y = cmd.sub[0] ? d : b;
    assign z = cmd.sub[0] ? b : d;

    chacha_qr u_qr (
      .x     (x),
      .y     (y),
      .z     (z),
      .sub   (cmd.sub),
      .x_new (lane_x_new[i]),
      .z_new (lane_z_new[i])
    );
  end

  // Route lane results back to their words: rows 0 and 2 take x, rows 1 and 3 take z.
  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
    localparam int ROW       = w / 4;
    localparam int COL       = w % 4;
    localparam int LANE_DIAG = (COL - ROW + 4) % 4;
    localparam bit ODD_SUB   = (ROW == 1) || (ROW == 2);
    localparam bit TAKES_X   = (ROW == 0) || (ROW == 2);

    word_t lane_val;

    if (TAKES_X) begin : g_x
      assign lane_val = cmd.diag ? lane_x_new[LANE_DIAG] : lane_x_new[COL];
    end else begin : g_z
      assign lane_val = cmd.diag ? lane_z_new[LANE_DIAG] : lane_z_new[COL];
    end

    assign round_next[w] = (cmd.sub[0] == ODD_SUB) ? lane_val : round_words[w];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      round_words <= init_words;
    end else if (cmd.step) begin
      round_words <= round_next;
    end
    if (cmd.finish) begin
      for (int n = 0; n < NUM_WORDS; n++) keystream[n] <= init_words[n] + round_words[n];
    end
  end

  assign ks_word = keystream[byte_pos[5:2]];
  assign ks_byte = 8'(ks_word >> {byte_pos[1:0], 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 4; n++) key_part[n] <= '0;
      nonce_low    <= '0;
      nonce_high   <= '0;
      init_counter <= 32'd1;
      block_count  <= 32'd1;
      byte_pos     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_PART_0:   key_part[0] <= cfg_data;
          REG_KEY_PART_1:   key_part[1] <= cfg_data;
          REG_KEY_PART_2:   key_part[2] <= cfg_data;
          REG_KEY_PART_3:   key_part[3] <= cfg_data;
          REG_NONCE_LOW:    nonce_low   <= cfg_data;
          REG_NONCE_HIGH:   nonce_high  <= cfg_data[31:0];
          REG_INIT_COUNTER: begin
            init_counter <= cfg_data[31:0];
            block_count  <= cfg_data[31:0];
          end
          default: ;
        endcase
      end
      if (cmd.accept) begin
        out_valid <= 1'b1;
        if (in_data.last_byte) begin
          byte_pos    <= '0;
          block_count <= init_counter;
        end else begin
          byte_pos <= byte_pos + 1'b1;
          if (&byte_pos) block_count <= block_count + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data.out_byte <= in_data.data_byte ^ ks_byte;
      out_data.last_out <= in_data.last_byte;
    end
  end

  assign status.pos_zero = (byte_pos == '0);
  assign status.out_free = !out_valid || out_ready;

  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> out_valid)
    else $error("accepted request produced no result");

endmodule
`default_nettype wire

FILE: rtl/chacha20_stream_cipher_top.sv
// Top level of the ChaCha20 byte-stream cipher.
//
//  channel  | signals                        | moves
//  ---------+--------------------------------+-----------------------------------
//  input    | in_valid, in_ready, in_data    | one message byte and last flag
//  output   | out_valid, out_ready, out_data | one ciphered byte and last flag
//  config   | cfg_we, cfg_index, cfg_data    | key, nonce, initial counter write
//
// A byte inside a block needs no block generation. A byte at block position zero first waits
// for block generation: a load step, the round steps (four quarter-round lanes, one
// add/xor/rotate each per cycle) and a final add step.
// Synchronous reset clears position, key, nonce and the output valid, and sets both counters to one.
// The result sits in an output register; a new request is taken while the
// downstream side takes the previous result.
`default_nettype none
module chacha20_stream_cipher_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [chacha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [chacha_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire chacha_pkg::in_item_t               in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output chacha_pkg::out_item_t                   out_data
);
  import chacha_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  chacha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  chacha_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

FILE: tb/sv/chacha_stream_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the ChaCha20 byte cipher: predicts each ciphered byte and checks the output.
module chacha_stream_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  chacha_pkg::in_item_t             in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  chacha_pkg::out_item_t            out_data,
  output int unsigned                      outstanding,
  output int unsigned                      mismatch_count
);
  import chacha_pkg::*;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_t;

  logic [KEY_PART_W-1:0] key_part [4];
  logic [63:0]           nonce_lo;
  logic [31:0]           nonce_hi;
  logic [31:0]           start_counter;
  logic [31:0]           block_counter;
  logic [POS_W-1:0]      byte_pos;
  block_t                keystream;
  out_item_t             expected_q [$];

  initial begin
    outstanding = 0;
    mismatch_count = 0;
  end

  function automatic word_t rotl(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic block_t quarter_round(input block_t w, input int a, input int b,
                                           input int c, input int d);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic block_t keystream_block(input word_t counter);
    block_t init_w;
    block_t w;
    for (int n = 0; n < 4; n++) begin
      init_w[n]         = SIGMA[n];
      init_w[4 + 2 * n] = key_part[n][31:0];
      init_w[5 + 2 * n] = key_part[n][63:32];
    end
    init_w[12] = counter;
    init_w[13] = nonce_lo[31:0];
    init_w[14] = nonce_lo[63:32];
    init_w[15] = nonce_hi;
    w = init_w;
    for (int r = 0; r < 10; r++) begin
      w = quarter_round(w, 0, 4, 8, 12);
      w = quarter_round(w, 1, 5, 9, 13);
      w = quarter_round(w, 2, 6, 10, 14);
      w = quarter_round(w, 3, 7, 11, 15);
      w = quarter_round(w, 0, 5, 10, 15);
      w = quarter_round(w, 1, 6, 11, 12);
      w = quarter_round(w, 2, 7, 8, 13);
      w = quarter_round(w, 3, 4, 9, 14);
    end
    for (int n = 0; n < NUM_WORDS; n++)
      w[n] = w[n] + init_w[n];
    return w;
  endfunction

  // Advance the cipher state by one byte and return the ciphered byte.
  function automatic out_item_t cipher_byte(input in_item_t req);
    out_item_t res;
    if (byte_pos == 0)
      keystream = keystream_block(block_counter);
    res.out_byte = req.data_byte ^ keystream[byte_pos[5:2]][byte_pos[1:0] * 8 +: 8];
    res.last_out = req.last_byte;
    if (req.last_byte) begin
      byte_pos = '0;
      block_counter = start_counter;
    end else begin
      byte_pos = byte_pos + 1'b1;
      if (byte_pos == 0)
        block_counter = block_counter + 1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int n = 0; n < 4; n++)
        key_part[n] = '0;
      nonce_lo = '0;
      nonce_hi = '0;
      start_counter = 32'd1;
      block_counter = 32'd1;
      byte_pos = '0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: out_byte %h last_out %b",
                 out_data.out_byte, out_data.last_out);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
            mismatch_count++;
          end
          if (out_data.last_out !== want.last_out) begin
            $error("last_out: expected %b, got %b", want.last_out, out_data.last_out);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(cipher_byte(in_data));
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_PART_0:   key_part[0] = cfg_data;
          REG_KEY_PART_1:   key_part[1] = cfg_data;
          REG_KEY_PART_2:   key_part[2] = cfg_data;
          REG_KEY_PART_3:   key_part[3] = cfg_data;
          REG_NONCE_LOW:    nonce_lo = cfg_data;
          REG_NONCE_HIGH:   nonce_hi = cfg_data[31:0];
          REG_INIT_COUNTER: begin
            // counter write takes effect for the next block made
            start_counter = cfg_data[31:0];
            block_counter = cfg_data[31:0];
          end
          default: ;
        endcase
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the ChaCha20 cipher testbench: clock, reset, stimulus and verdict.
module testbench;
  import chacha_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 95;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  int unsigned           outstanding;
  int unsigned           mismatch_count;
  bit                    steady;
  int unsigned           ready_hold;
  int unsigned           msg_left;

  chacha20_stream_cipher_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  chacha_stream_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(negedge clk) begin
    if (rst || steady) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        ready_hold <= idle_gap();
      end
    end else begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {data, last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_message_byte();
    int unsigned r;
    if (msg_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        msg_left = $urandom_range(1, 8);
      else if (r < 65)
        msg_left = $urandom_range(9, 63);
      else if (r < 80)
        msg_left = 63 + $urandom_range(0, 2);
      else
        msg_left = $urandom_range(66, 200);
    end
    send_byte(8'($urandom_range(0, 255)), msg_left == 1);
    msg_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Drop the request and wait until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_config(input int unsigned phase);
    logic [63:0] key_fill [4];
    logic [63:0] nonce_fill;
    logic [31:0] nonce_top;
    logic [31:0] counter;
    for (int n = 0; n < 4; n++)
      key_fill[n] = {$urandom, $urandom};
    nonce_fill = {$urandom, $urandom};
    nonce_top = $urandom;
    counter = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff - $urandom_range(0, 2) : $urandom;
    if (phase == 0) begin
      for (int n = 0; n < 4; n++)
        key_fill[n] = '0;
      nonce_fill = '0;
      nonce_top = '0;
      counter = '0;
    end else if (phase == 1) begin
      for (int n = 0; n < 4; n++)
        key_fill[n] = '1;
      nonce_fill = '1;
      nonce_top = '1;
      counter = '1;
    end
    write_reg(REG_KEY_PART_0, key_fill[0]);
    write_reg(REG_KEY_PART_1, key_fill[1]);
    write_reg(REG_KEY_PART_2, key_fill[2]);
    write_reg(REG_KEY_PART_3, key_fill[3]);
    write_reg(REG_NONCE_LOW, nonce_fill);
    // junk in the upper half must be dropped
    write_reg(REG_NONCE_HIGH, {$urandom, nonce_top});
    write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(REG_INIT_COUNTER, {$urandom, counter});
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    steady = 1'b0;
    ready_hold = 0;
    msg_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset key and counter, short messages and single-byte messages
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();

    // well-known key and nonce, counter one
    write_reg(REG_KEY_PART_0, 64'h0706050403020100);
    write_reg(REG_KEY_PART_1, 64'h0f0e0d0c0b0a0908);
    write_reg(REG_KEY_PART_2, 64'h1716151413121110);
    write_reg(REG_KEY_PART_3, 64'h1f1e1d1c1b1a1918);
    write_reg(REG_NONCE_LOW, 64'h4a000000_09000000);
    write_reg(REG_NONCE_HIGH, 64'h0);
    write_reg(REG_INIT_COUNTER, 64'h1);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      load_config(p);
      steady <= ($urandom_range(0, 3) == 0);
      // all-ones counter: run past the wrap to zero
      if (p == 1)
        msg_left = 130;
      repeat (PHASE_ITEMS) send_message_byte();
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/chacha_pkg.sv
rtl/chacha_qr.sv
rtl/chacha_ctrl.sv
rtl/chacha_dp.sv
rtl/chacha20_stream_cipher_top.sv
tb/sv/chacha_stream_checker.sv
tb/sv/testbench.sv
